@@ hdl/fapt_pkg.sv @@
`timescale 1ns / 1ps

package fapt_pkg;

    // Longest packet prefix that is examined; later bytes only count for the end mark.
    localparam int MAX_PACKET_BYTES = 4096;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    // Both internal queues hold two entries.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CONTROL_PORT_RESET = 16'd21;
    localparam logic [7:0]  TCP_PROTO          = 8'd6;
    localparam logic [7:0]  CHAR_COMMA         = 8'h2C;
    localparam logic [7:0]  CHAR_ZERO          = 8'h30;
    localparam logic [7:0]  CHAR_NINE          = 8'h39;
    localparam int          FIELD_COUNT        = 6;
    localparam int          FIELD_W            = $clog2(FIELD_COUNT + 1);

    // Result classes.
    typedef enum logic [2:0] {
        CLASS_NONE       = 3'd0,
        CLASS_TCP        = 3'd1,
        CLASS_STATUS     = 3'd2,
        CLASS_PORT_CMD   = 3'd3,
        CLASS_DATA       = 3'd4,
        CLASS_DATA_EMPTY = 3'd5,
        CLASS_CONTROL    = 3'd6
    } packet_class_t;

    // Everything the back end needs to know about one finished packet.
    typedef struct packed {
        logic        tcp_ok;
        logic        got_status;
        logic        got_port;
        logic [15:0] dest_port;
        logic [31:0] source;
        logic [15:0] total_length;
        logic [6:0]  hdr_bytes;
        logic [31:0] port_host;
        logic [15:0] port_number;
    } fapt_summary_t;

    // One result request.
    typedef struct packed {
        packet_class_t pclass;
        logic [31:0]   source;
        logic [31:0]   client;
        logic [31:0]   host;
        logic [15:0]   port;
        logic [15:0]   plen;
        logic [31:0]   count;
    } fapt_result_t;

    // Characters of the status keyword "150".
    function automatic logic [7:0] key_status_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h31;
            2'd1:    c = 8'h35;
            2'd2:    c = 8'h30;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the command keyword "PORT".
    function automatic logic [7:0] key_port_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h50;
            2'd1:    c = 8'h4F;
            2'd2:    c = 8'h52;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/fapt_front.sv @@
`timescale 1ns / 1ps

module fapt_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             packet_byte,
    input  logic                   last_byte,
    output logic                   summary_push,
    output fapt_pkg::fapt_summary_t summary
);

    logic [fapt_pkg::POS_W-1:0]   pos_reg, pos_next, pos_upd;
    logic [3:0]                   ihl_reg, ihl_next, ihl_upd;
    logic [15:0]                  tot_reg, tot_next, tot_upd;
    logic [7:0]                   proto_reg, proto_next, proto_upd;
    logic [31:0]                  src_reg, src_next, src_upd;
    logic [15:0]                  dport_reg, dport_next, dport_upd;
    logic [3:0]                   doff_reg, doff_next, doff_upd;
    logic                         cs_reg, cs_next, cs_upd;
    logic                         cp_reg, cp_next, cp_upd;
    logic                         gs_reg, gs_next, gs_upd;
    logic                         gp_reg, gp_next, gp_upd;
    logic [fapt_pkg::FIELD_W-1:0] fi_reg, fi_next, fi_upd;
    logic [1:0]                   dc_reg, dc_next, dc_upd;
    logic [9:0]                   acc_reg, acc_next, acc_upd;
    logic [7:0]                   fld_reg [fapt_pkg::FIELD_COUNT];
    logic [7:0]                   fld_upd [fapt_pkg::FIELD_COUNT];
    logic [7:0]                   fld_fin [fapt_pkg::FIELD_COUNT];

    logic [fapt_pkg::POS_W-1:0]   ip_hdr, hdr_sum, idx, count, ip_hdr_fin;

    assign ip_hdr  = fapt_pkg::POS_W'({ihl_reg, 2'b00});
    assign hdr_sum = ip_hdr + fapt_pkg::POS_W'({doff_reg, 2'b00});
    assign idx     = pos_reg - hdr_sum;

    // Header capture, keyword match and decimal parse of one byte.
    always_comb
    begin
        pos_upd   = pos_reg;
        ihl_upd   = ihl_reg;
        tot_upd   = tot_reg;
        proto_upd = proto_reg;
        src_upd   = src_reg;
        dport_upd = dport_reg;
        doff_upd  = doff_reg;
        cs_upd    = cs_reg;
        cp_upd    = cp_reg;
        gs_upd    = gs_reg;
        gp_upd    = gp_reg;
        fi_upd    = fi_reg;
        dc_upd    = dc_reg;
        acc_upd   = acc_reg;
        fld_upd   = fld_reg;
        if (pos_reg != fapt_pkg::POS_W'(fapt_pkg::MAX_PACKET_BYTES))
        begin
            if (pos_reg == fapt_pkg::POS_W'(0))
                ihl_upd = packet_byte[3:0];
            if (pos_reg == fapt_pkg::POS_W'(2))
                tot_upd[15:8] = packet_byte;
            if (pos_reg == fapt_pkg::POS_W'(3))
                tot_upd[7:0] = packet_byte;
            if (pos_reg == fapt_pkg::POS_W'(9))
                proto_upd = packet_byte;
            if (pos_reg inside {[12:15]})
                src_upd = {src_reg[23:0], packet_byte};
            if (pos_reg == ip_hdr + fapt_pkg::POS_W'(2))
                dport_upd[15:8] = packet_byte;
            if (pos_reg == ip_hdr + fapt_pkg::POS_W'(3))
                dport_upd[7:0] = packet_byte;
            if (pos_reg == ip_hdr + fapt_pkg::POS_W'(12))
                doff_upd = packet_byte[7:4];
            // Payload bytes after the data offset byte.
            if ((pos_reg > ip_hdr + fapt_pkg::POS_W'(12)) && (pos_reg >= hdr_sum))
            begin
                if (idx == fapt_pkg::POS_W'(0))
                begin
                    cs_upd = 1'b1;
                    cp_upd = 1'b1;
                end
                if (idx < fapt_pkg::POS_W'(3))
                begin
                    if (packet_byte != fapt_pkg::key_status_char(idx[1:0]))
                        cs_upd = 1'b0;
                    if (idx == fapt_pkg::POS_W'(2) && cs_upd)
                        gs_upd = 1'b1;
                end
                if (idx < fapt_pkg::POS_W'(4))
                begin
                    if (packet_byte != fapt_pkg::key_port_char(idx[1:0]))
                        cp_upd = 1'b0;
                    if (idx == fapt_pkg::POS_W'(3) && cp_upd)
                    begin
                        gp_upd  = 1'b1;
                        fi_upd  = '0;
                        dc_upd  = '0;
                        acc_upd = '0;
                        for (int i = 0; i < fapt_pkg::FIELD_COUNT; i++)
                            fld_upd[i] = '0;
                    end
                end
                // Arguments of the PORT command, one character per byte.
                if (idx >= fapt_pkg::POS_W'(5) && gp_upd &&
                    fi_upd < fapt_pkg::FIELD_W'(fapt_pkg::FIELD_COUNT))
                begin
                    if (packet_byte == fapt_pkg::CHAR_COMMA)
                    begin
                        fld_upd[fi_upd] = acc_upd[7:0];
                        fi_upd  = fi_upd + fapt_pkg::FIELD_W'(1);
                        acc_upd = '0;
                        dc_upd  = '0;
                    end
                    else if (packet_byte inside {[fapt_pkg::CHAR_ZERO:fapt_pkg::CHAR_NINE]} &&
                             dc_upd != 2'd3)
                    begin
                        acc_upd = {acc_upd[6:0], 3'b000} + {acc_upd[8:0], 1'b0}
                                  + {6'd0, packet_byte[3:0]};
                        dc_upd  = dc_upd + 2'd1;
                    end
                    else
                    begin
                        dc_upd = 2'd3;
                    end
                end
            end
            pos_upd = pos_reg + fapt_pkg::POS_W'(1);
        end
    end

    // Packet summary, with the open PORT field closed at the end mark.
    always_comb
    begin
        fld_fin = fld_upd;
        if (gp_upd && fi_upd < fapt_pkg::FIELD_W'(fapt_pkg::FIELD_COUNT))
            fld_fin[fi_upd] = acc_upd[7:0];
    end

    assign count      = pos_upd;
    assign ip_hdr_fin = fapt_pkg::POS_W'({ihl_upd, 2'b00});

    assign summary.tcp_ok       = (count >= fapt_pkg::POS_W'(20)) &&
                                  (count > ip_hdr_fin + fapt_pkg::POS_W'(12)) &&
                                  (proto_upd == fapt_pkg::TCP_PROTO);
    assign summary.got_status   = gs_upd;
    assign summary.got_port     = gp_upd;
    assign summary.dest_port    = dport_upd;
    assign summary.source       = src_upd;
    assign summary.total_length = tot_upd;
    assign summary.hdr_bytes    = {1'b0, ihl_upd, 2'b00} + {1'b0, doff_upd, 2'b00};
    assign summary.port_host    = {fld_fin[0], fld_fin[1], fld_fin[2], fld_fin[3]};
    assign summary.port_number  = {fld_fin[4], fld_fin[5]};
    assign summary_push         = take && last_byte;

    // Next state: per-packet state clears after the end mark.
    always_comb
    begin
        pos_next   = pos_reg;
        ihl_next   = ihl_reg;
        tot_next   = tot_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dport_next = dport_reg;
        doff_next  = doff_reg;
        cs_next    = cs_reg;
        cp_next    = cp_reg;
        gs_next    = gs_reg;
        gp_next    = gp_reg;
        fi_next    = fi_reg;
        dc_next    = dc_reg;
        acc_next   = acc_reg;
        if (take && last_byte)
        begin
            pos_next   = '0;
            ihl_next   = '0;
            tot_next   = '0;
            proto_next = '0;
            src_next   = '0;
            dport_next = '0;
            doff_next  = '0;
            cs_next    = 1'b0;
            cp_next    = 1'b0;
            gs_next    = 1'b0;
            gp_next    = 1'b0;
            fi_next    = '0;
            dc_next    = '0;
            acc_next   = '0;
        end
        else if (take)
        begin
            pos_next   = pos_upd;
            ihl_next   = ihl_upd;
            tot_next   = tot_upd;
            proto_next = proto_upd;
            src_next   = src_upd;
            dport_next = dport_upd;
            doff_next  = doff_upd;
            cs_next    = cs_upd;
            cp_next    = cp_upd;
            gs_next    = gs_upd;
            gp_next    = gp_upd;
            fi_next    = fi_upd;
            dc_next    = dc_upd;
            acc_next   = acc_upd;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ihl_reg   <= '0;
            tot_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dport_reg <= '0;
            doff_reg  <= '0;
            cs_reg    <= 1'b0;
            cp_reg    <= 1'b0;
            gs_reg    <= 1'b0;
            gp_reg    <= 1'b0;
            fi_reg    <= '0;
            dc_reg    <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            ihl_reg   <= ihl_next;
            tot_reg   <= tot_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dport_reg <= dport_next;
            doff_reg  <= doff_next;
            cs_reg    <= cs_next;
            cp_reg    <= cp_next;
            gs_reg    <= gs_next;
            gp_reg    <= gp_next;
            fi_reg    <= fi_next;
            dc_reg    <= dc_next;
            acc_reg   <= acc_next;
        end
    end

    // Parsed PORT fields are only read after a PORT match has cleared them.
    always_ff @(posedge clk)
    begin
        if (take)
            fld_reg <= fld_upd;
    end

endmodule

@@ hdl/fapt_summary_queue.sv @@
`timescale 1ns / 1ps

module fapt_summary_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fapt_pkg::fapt_summary_t push_data,
    output logic                    full,
    input  logic                    pop,
    output logic                    empty,
    output fapt_pkg::fapt_summary_t head
);

    fapt_pkg::fapt_summary_t       mem [fapt_pkg::QUEUE_DEPTH];
    logic [fapt_pkg::PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [fapt_pkg::PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [fapt_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    assign full    = (cnt_reg == fapt_pkg::CNT_W'(fapt_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + fapt_pkg::PTR_W'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + fapt_pkg::PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + fapt_pkg::CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - fapt_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hdl/fapt_back.sv @@
`timescale 1ns / 1ps

module fapt_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    control_port_we,
    input  logic [15:0]             control_port_wdata,
    input  logic                    sum_empty,
    input  fapt_pkg::fapt_summary_t sum_head,
    output logic                    sum_pop,
    input  logic                    pop,
    output logic                    empty,
    output fapt_pkg::fapt_result_t  result
);

    logic [15:0]                control_port_reg;
    logic [31:0]                client_reg, client_next;
    logic [31:0]                host_reg, host_next;
    logic [15:0]                port_reg, port_next;
    logic [31:0]                seen_reg, seen_next;
    logic [15:0]                plen;
    fapt_pkg::packet_class_t    pclass;
    fapt_pkg::fapt_result_t     res_new;

    fapt_pkg::fapt_result_t     mem [fapt_pkg::QUEUE_DEPTH];
    logic [fapt_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [fapt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       res_full, res_push, res_pop;

    assign res_full = (cnt_reg == fapt_pkg::CNT_W'(fapt_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign res_push = !sum_empty && !res_full;
    assign res_pop  = pop && !empty;
    assign sum_pop  = res_push;
    assign result   = mem[rd_ptr_reg];

    // Classification of the oldest packet and tracked connection update.
    always_comb
    begin
        client_next = client_reg;
        host_next   = host_reg;
        port_next   = port_reg;
        seen_next   = seen_reg + 32'd1;
        plen        = '0;
        pclass      = fapt_pkg::CLASS_NONE;
        if (sum_head.tcp_ok)
        begin
            if (sum_head.total_length > {9'd0, sum_head.hdr_bytes})
                plen = sum_head.total_length - {9'd0, sum_head.hdr_bytes};
            if (sum_head.dest_port == control_port_reg)
            begin
                if (sum_head.got_status)
                begin
                    pclass      = fapt_pkg::CLASS_STATUS;
                    client_next = sum_head.source;
                end
                else if (sum_head.got_port)
                begin
                    pclass    = fapt_pkg::CLASS_PORT_CMD;
                    host_next = sum_head.port_host;
                    port_next = sum_head.port_number;
                end
                else
                begin
                    pclass = fapt_pkg::CLASS_CONTROL;
                end
            end
            else if (port_reg != '0 && sum_head.dest_port == port_reg)
            begin
                pclass = (plen != '0) ? fapt_pkg::CLASS_DATA : fapt_pkg::CLASS_DATA_EMPTY;
            end
            else
            begin
                pclass = fapt_pkg::CLASS_TCP;
            end
        end
    end

    assign res_new.pclass = pclass;
    assign res_new.source = sum_head.source;
    assign res_new.client = client_next;
    assign res_new.host   = host_next;
    assign res_new.port   = port_next;
    assign res_new.plen   = plen;
    assign res_new.count  = seen_next;

    // Result queue fill level.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (res_push && !res_pop)
            cnt_next = cnt_reg + fapt_pkg::CNT_W'(1);
        else if (res_pop && !res_push)
            cnt_next = cnt_reg - fapt_pkg::CNT_W'(1);
    end

    // Tracked state, configuration and queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_port_reg <= fapt_pkg::CONTROL_PORT_RESET;
            client_reg       <= '0;
            host_reg         <= '0;
            port_reg         <= '0;
            seen_reg         <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            cnt_reg          <= '0;
        end
        else
        begin
            if (control_port_we)
                control_port_reg <= control_port_wdata;
            if (res_push)
            begin
                client_reg <= client_next;
                host_reg   <= host_next;
                port_reg   <= port_next;
                seen_reg   <= seen_next;
                wr_ptr_reg <= wr_ptr_reg + fapt_pkg::PTR_W'(1);
            end
            if (res_pop)
                rd_ptr_reg <= rd_ptr_reg + fapt_pkg::PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (res_push)
            mem[wr_ptr_reg] <= res_new;
    end

endmodule

@@ hdl/ftp_active_port_tracker.sv @@
`timescale 1ns / 1ps
// Channel         Handshake      Payload
// configuration   control_port_we control_port_wdata (16 bits)
// packet bytes    push / full    packet_byte (8), last_byte (1)
// results         pop / empty    packet_class, source_addr, client_addr, data_host,
//                                data_port, payload_length, packet_count
//
// One packet byte is taken per cycle while full is low; each packet gives one
// result request. A result is registered in the summary queue, then in the
// result queue, after its last byte is taken; the parser adds no register.
// rst_n clears all but the queue and field stores at once; no start-up sweep.
// full rises only while the two-entry summary queue is full, which happens when
// results are not popped and the two-entry result queue has also filled.

module ftp_active_port_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        control_port_we,
    input  logic [15:0] control_port_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  packet_class,
    output logic [31:0] source_addr,
    output logic [31:0] client_addr,
    output logic [31:0] data_host,
    output logic [15:0] data_port,
    output logic [15:0] payload_length,
    output logic [31:0] packet_count
);

    logic                    take;
    logic                    summary_push;
    logic                    sum_empty;
    logic                    sum_pop;
    fapt_pkg::fapt_summary_t summary;
    fapt_pkg::fapt_summary_t sum_head;
    fapt_pkg::fapt_result_t  result;

    // A byte is taken whenever the summary queue has room.
    assign take = push && !full;

    fapt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .packet_byte  (packet_byte),
        .last_byte    (last_byte),
        .summary_push (summary_push),
        .summary      (summary)
    );

    fapt_summary_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (summary_push),
        .push_data (summary),
        .full      (full),
        .pop       (sum_pop),
        .empty     (sum_empty),
        .head      (sum_head)
    );

    fapt_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .control_port_we    (control_port_we),
        .control_port_wdata (control_port_wdata),
        .sum_empty          (sum_empty),
        .sum_head           (sum_head),
        .sum_pop            (sum_pop),
        .pop                (pop),
        .empty              (empty),
        .result             (result)
    );

    // Result fields onto their ports.
    assign packet_class   = result.pclass;
    assign source_addr    = result.source;
    assign client_addr    = result.client;
    assign data_host      = result.host;
    assign data_port      = result.port;
    assign payload_length = result.plen;
    assign packet_count   = result.count;

endmodule
